[sv/clfsr_pkg.sv]
`timescale 1ns / 1ps

package clfsr_pkg;

    // widest register the cell row supports
    localparam int MAX_WIDTH = 64;
    localparam int SIZE_W    = 7;

    // register width and seed after reset
    localparam logic [SIZE_W-1:0]    RESET_SIZE  = 7'd16;
    localparam logic [MAX_WIDTH-1:0] RESET_STATE = 64'h0000_0000_0000_ffff;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_SIZE  = 3'd0,
        REG_KIND  = 3'd1,
        REG_DIR   = 3'd2,
        REG_TAPS  = 3'd3,
        REG_START = 3'd4,
        REG_CHECK = 3'd5
    } clfsr_reg_t;

    // result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_CHECK_FAIL = 2'd1;
    localparam logic [1:0] ST_NO_TAPS    = 2'd2;

    // settings derived from the configuration registers
    typedef struct packed {
        logic [MAX_WIDTH-1:0] mask;
        logic [MAX_WIDTH-1:0] top;
        logic [MAX_WIDTH-1:0] seed;
        logic [MAX_WIDTH-1:0] taps;
        logic                 no_taps;
        logic                 galois;
        logic                 left;
        logic                 check;
    } clfsr_derived_t;

    // built-in primitive polynomials, zero where the width has none
    function automatic logic [MAX_WIDTH-1:0] clfsr_poly(input logic [SIZE_W-1:0] w);
        logic [MAX_WIDTH-1:0] p;
        begin
            case (w)
                7'd2:    p = 64'h3;
                7'd3:    p = 64'h3;
                7'd4:    p = 64'h3;
                7'd5:    p = 64'h5;
                7'd6:    p = 64'h3;
                7'd7:    p = 64'h3;
                7'd8:    p = 64'h1d;
                7'd9:    p = 64'h11;
                7'd10:   p = 64'h9;
                7'd11:   p = 64'h5;
                7'd12:   p = 64'h107;
                7'd13:   p = 64'h27;
                7'd14:   p = 64'h1007;
                7'd15:   p = 64'h3;
                7'd16:   p = 64'h100b;
                7'd17:   p = 64'h9;
                7'd18:   p = 64'h81;
                7'd19:   p = 64'h27;
                7'd20:   p = 64'h9;
                7'd21:   p = 64'h5;
                7'd22:   p = 64'h3;
                7'd23:   p = 64'h21;
                7'd24:   p = 64'h87;
                7'd31:   p = 64'h9;
                default: p = '0;
            endcase
            return p;
        end
    endfunction

    // reverse the low w bits of v
    function automatic logic [MAX_WIDTH-1:0] clfsr_mirror(input logic [SIZE_W-1:0] w,
                                                          input logic [MAX_WIDTH-1:0] v);
        logic [MAX_WIDTH-1:0] r;
        logic [SIZE_W-1:0]    src;
        begin
            r = '0;
            for (int j = 0; j < MAX_WIDTH; j++)
            begin
                src = w - 7'd1 - SIZE_W'(j);
                if (SIZE_W'(j) < w)
                begin
                    r[j] = v[src[5:0]];
                end
            end
            return r;
        end
    endfunction

endpackage

[sv/clfsr_cfg.sv]
`timescale 1ns / 1ps

module clfsr_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [63:0]                  cfg_wdata,
    output clfsr_pkg::clfsr_derived_t    derived,
    output logic                         busy
);
    import clfsr_pkg::*;

    logic [SIZE_W-1:0]    size_reg;
    logic                 kind_reg;
    logic                 dir_reg;
    logic [MAX_WIDTH-1:0] taps_reg;
    logic [MAX_WIDTH-1:0] start_reg;
    logic                 check_reg;
    logic                 busy_reg;
    clfsr_derived_t       derived_reg;
    clfsr_derived_t       derived_next;

    logic [SIZE_W-1:0]    eff_w;
    logic [MAX_WIDTH-1:0] taps_m;
    logic [MAX_WIDTH-1:0] taps_sel;
    logic [MAX_WIDTH-1:0] start_m;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= RESET_SIZE;
            kind_reg  <= 1'b0;
            dir_reg   <= 1'b0;
            taps_reg  <= '0;
            start_reg <= '0;
            check_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SIZE:  size_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_KIND:  kind_reg  <= cfg_wdata[0];
                REG_DIR:   dir_reg   <= cfg_wdata[0];
                REG_TAPS:  taps_reg  <= cfg_wdata;
                REG_START: start_reg <= cfg_wdata;
                REG_CHECK: check_reg <= cfg_wdata[0];
                default:   ;
            endcase
        end
    end

    // effective width, masks, seed and taps
    always_comb
    begin
        if (size_reg < 7'd2)
        begin
            eff_w = 7'd2;
        end
        else if (size_reg > SIZE_W'(MAX_WIDTH))
        begin
            eff_w = SIZE_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = size_reg;
        end

        derived_next = '0;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            derived_next.mask[i] = (SIZE_W'(i) < eff_w);
            derived_next.top[i]  = (SIZE_W'(i) == (eff_w - 7'd1));
        end

        taps_m = taps_reg & derived_next.mask;
        if (taps_m == '0)
        begin
            taps_sel = kind_reg ? clfsr_mirror(eff_w, clfsr_poly(eff_w)) : clfsr_poly(eff_w);
        end
        else
        begin
            taps_sel = taps_m;
        end

        start_m = start_reg & derived_next.mask;

        derived_next.taps    = taps_sel;
        derived_next.no_taps = (taps_sel == '0);
        derived_next.seed    = (start_m == '0) ? derived_next.mask : start_m;
        derived_next.galois  = kind_reg;
        derived_next.left    = dir_reg;
        derived_next.check   = check_reg;
    end

    // derived settings are registered again from the configuration registers
    always_ff @(posedge clk)
    begin
        derived_reg <= derived_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= cfg_we;
        end
    end

    assign derived = derived_reg;
    assign busy    = busy_reg;

endmodule

[sv/clfsr_cell.sv]
`timescale 1ns / 1ps

module clfsr_cell #(
    parameter logic RST_VAL = 1'b0
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic load,
    input  logic seed_bit,
    input  logic nbr_bit,
    input  logic inj_bit,
    input  logic mask_bit,
    input  logic tap_bit,
    output logic q,
    output logic qm,
    output logic d,
    output logic prod
);

    logic state_reg;
    logic state_next;

    // seed bit on load, else the shifted-in neighbor bit plus feedback, masked to the width
    always_comb
    begin
        if (load)
        begin
            state_next = seed_bit;
        end
        else
        begin
            state_next = (nbr_bit ^ inj_bit) & mask_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RST_VAL;
        end
        else if (en)
        begin
            state_reg <= state_next;
        end
    end

    assign q    = state_reg;
    assign qm   = state_reg & mask_bit;
    assign d    = state_next;
    assign prod = tap_bit & state_reg;

endmodule

[sv/configurable_lfsr_generator_core.sv]
`timescale 1ns / 1ps

// Configurable LFSR, Fibonacci or Galois, 2 to 64 bits, shifting either way.
// The register is a row of one-bit cells; each accepted transfer advances it
// one step (or reloads the seed on restart, or holds when no taps are set) and
// the result appears in the output register on the next cycle, so one item is
// taken every clock while the output side keeps up. Taps, seed and width are
// decoded into a settings register, so input is stalled as reset ends and in
// the cycle after every configuration write. The phase wrap test compares the
// old phase with the last phase of the period side by side with the increment,
// in the same cycle as the shift.
module configurable_lfsr_generator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        out_bit,
    output logic [63:0] state_value,
    output logic [63:0] phase_count,
    output logic        period_complete,
    output logic [1:0]  status
);
    import clfsr_pkg::*;

    clfsr_derived_t       cfg;
    logic                 cfg_busy;

    logic [MAX_WIDTH-1:0] q;
    logic [MAX_WIDTH-1:0] qm;
    logic [MAX_WIDTH-1:0] d;
    logic [MAX_WIDTH-1:0] prod;
    logic [MAX_WIDTH-1:0] nbr;
    logic [MAX_WIDTH-1:0] inj;
    logic                 obit;
    logic                 nb;

    logic                 out_ready;
    logic                 fire;
    logic                 step;
    logic                 cell_en;

    logic [MAX_WIDTH-1:0] phase_reg;
    logic [MAX_WIDTH-1:0] phase_next;
    logic [MAX_WIDTH-1:0] phase_inc;
    logic                 phase_wrap;
    logic                 done;

    logic                 out_valid_reg;
    logic                 out_bit_reg;
    logic [MAX_WIDTH-1:0] state_value_reg;
    logic [MAX_WIDTH-1:0] phase_count_reg;
    logic                 period_complete_reg;
    logic [1:0]           status_reg;
    logic                 out_bit_next;
    logic [MAX_WIDTH-1:0] state_value_next;
    logic                 period_complete_next;
    logic [1:0]           status_next;

    // configuration registers and decoded settings
    clfsr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .derived   (cfg),
        .busy      (cfg_busy)
    );

    // handshake
    assign out_ready = !out_valid_reg || !out_stall;
    assign in_stall  = cfg_busy || !out_ready;
    assign fire      = in_valid && !in_stall;
    assign step      = fire && !restart && !cfg.no_taps;
    assign cell_en   = fire && (restart || !cfg.no_taps);

    // feedback: bit shifted out and Fibonacci parity
    assign obit = cfg.left ? |(qm & cfg.top) : qm[0];
    assign nb   = ^prod;

    // neighbor wiring and feedback injection per cell
    always_comb
    begin
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            if (cfg.left)
            begin
                nbr[i] = (i == 0) ? 1'b0 : qm[(i == 0) ? 0 : i - 1];
            end
            else
            begin
                nbr[i] = (i == MAX_WIDTH - 1) ? 1'b0 : qm[(i == MAX_WIDTH - 1) ? i : i + 1];
            end

            if (cfg.galois)
            begin
                inj[i] = obit & cfg.taps[i];
            end
            else if (cfg.left)
            begin
                inj[i] = (i == 0) ? nb : 1'b0;
            end
            else
            begin
                inj[i] = cfg.top[i] & nb;
            end
        end
    end

    // row of state cells
    for (genvar g = 0; g < MAX_WIDTH; g++)
    begin : g_cell
        clfsr_cell #(
            .RST_VAL (RESET_STATE[g])
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (cell_en),
            .load     (restart),
            .seed_bit (cfg.seed[g]),
            .nbr_bit  (nbr[g]),
            .inj_bit  (inj[g]),
            .mask_bit (cfg.mask[g]),
            .tap_bit  (cfg.taps[g]),
            .q        (q[g]),
            .qm       (qm[g]),
            .d        (d[g]),
            .prod     (prod[g])
        );
    end

    // phase counter wrapping at 2^size-1
    always_comb
    begin
        phase_inc  = phase_reg + 64'd1;
        phase_wrap = (phase_reg >= {cfg.mask[MAX_WIDTH-1:1], 1'b0});
        if (restart || phase_wrap)
        begin
            phase_next = '0;
        end
        else
        begin
            phase_next = phase_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (cell_en)
        begin
            phase_reg <= phase_next;
        end
    end

    // result of this transfer
    always_comb
    begin
        done                 = (d == cfg.seed);
        out_bit_next         = 1'b0;
        period_complete_next = 1'b0;
        state_value_next     = cell_en ? d : q;
        status_next          = ST_OK;
        if (restart)
        begin
            status_next = cfg.no_taps ? ST_NO_TAPS : ST_OK;
        end
        else if (cfg.no_taps)
        begin
            status_next = ST_NO_TAPS;
        end
        else
        begin
            out_bit_next         = obit;
            period_complete_next = done;
            if (cfg.check && ((d == '0) || (done != phase_wrap)))
            begin
                status_next = ST_CHECK_FAIL;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_bit_reg         <= out_bit_next;
            state_value_reg     <= state_value_next;
            phase_count_reg     <= cell_en ? phase_next : phase_reg;
            period_complete_reg <= period_complete_next;
            status_reg          <= status_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_bit         = out_bit_reg;
    assign state_value     = state_value_reg;
    assign phase_count     = phase_count_reg;
    assign period_complete = period_complete_reg;
    assign status          = status_reg;

`ifndef SYNTHESIS
    // a restart transfer shows a cleared phase and no completion
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && restart) |=> (out_valid && (phase_count == '0) && !period_complete && !out_bit))
        else $error("restart result not cleared");

    // a step without taps reports the missing polynomial
    a_no_taps: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !restart && cfg.no_taps) |=> (status == ST_NO_TAPS))
        else $error("missing taps not reported");

    // input is held off while decoded settings catch up with a write
    a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> in_stall)
        else $error("transfer accepted during settings update");

    // a real step keeps the register inside the configured width
    a_state_width: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> ((d & ~cfg.mask) == '0))
        else $error("state bits above width");
`endif

endmodule

[tb/configurable_lfsr_generator_core_tb.sv]
`timescale 1ns / 1ps

module configurable_lfsr_generator_core_tb;
    import clfsr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    // one step of the register as seen on the result side
    typedef struct packed {
        logic                 out_bit;
        logic [MAX_WIDTH-1:0] state_value;
        logic [MAX_WIDTH-1:0] phase_count;
        logic                 period_complete;
        logic [1:0]           status;
    } lfsr_step_t;

    // shadow of the generator plus the queue of steps still owed by the block
    class lfsr_step_checker;
        logic [SIZE_W-1:0]    size_reg;
        logic                 galois;
        logic                 left;
        logic [MAX_WIDTH-1:0] taps_reg;
        logic [MAX_WIDTH-1:0] start_reg;
        logic                 check_on;
        logic [MAX_WIDTH-1:0] lfsr_q;
        logic [MAX_WIDTH-1:0] phase_q;
        lfsr_step_t           owed_steps[$];
        int                   mismatches;
        int                   matched;
        int                   completions;
        int                   check_flags;
        int                   no_tap_steps;

        function new();
            size_reg     = RESET_SIZE;
            galois       = 1'b0;
            left         = 1'b0;
            taps_reg     = '0;
            start_reg    = '0;
            check_on     = 1'b1;
            lfsr_q       = RESET_STATE;
            phase_q      = '0;
            mismatches   = 0;
            matched      = 0;
            completions  = 0;
            check_flags  = 0;
            no_tap_steps = 0;
        endfunction

        function int pending();
            return owed_steps.size();
        endfunction

        function void set_reg(clfsr_reg_t idx, logic [63:0] value);
            case (idx)
                REG_SIZE:  size_reg  = value[SIZE_W-1:0];
                REG_KIND:  galois    = value[0];
                REG_DIR:   left      = value[0];
                REG_TAPS:  taps_reg  = value;
                REG_START: start_reg = value;
                REG_CHECK: check_on  = value[0];
                default:   ;
            endcase
        endfunction

        // primitive polynomial per width, zero where there is none
        function logic [MAX_WIDTH-1:0] builtin_taps(int unsigned w);
            case (w)
                2, 3, 4, 6, 7, 15, 22: return 64'h3;
                5, 11, 21:             return 64'h5;
                8:                     return 64'h1d;
                9:                     return 64'h11;
                10, 17, 20, 31:        return 64'h9;
                12:                    return 64'h107;
                13, 19:                return 64'h27;
                14:                    return 64'h1007;
                16:                    return 64'h100b;
                18:                    return 64'h81;
                23:                    return 64'h21;
                24:                    return 64'h87;
                default:               return '0;
            endcase
        endfunction

        function logic [MAX_WIDTH-1:0] reverse_low(int unsigned w, logic [MAX_WIDTH-1:0] v);
            logic [MAX_WIDTH-1:0] r;
            r = '0;
            for (int k = 0; k < w; k++)
                r[w - 1 - k] = v[k];
            return r;
        endfunction

        // advance the shadow register for one accepted input transfer
        function void note_transfer(logic restart_bit);
            int unsigned          w;
            logic [MAX_WIDTH-1:0] mask;
            logic [MAX_WIDTH-1:0] seed;
            logic [MAX_WIDTH-1:0] taps;
            logic [MAX_WIDTH-1:0] s;
            logic [MAX_WIDTH-1:0] nxt;
            logic                 nb;
            lfsr_step_t           r;

            w = (size_reg < 2) ? 2 : ((size_reg > MAX_WIDTH) ? MAX_WIDTH : size_reg);
            mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
            seed = start_reg & mask;
            if (seed == '0)
                seed = mask;
            taps = taps_reg & mask;
            if (taps == '0)
            begin
                taps = builtin_taps(w);
                if (galois)
                    taps = reverse_low(w, taps);
            end
            r = '0;

            if (restart_bit)
            begin
                lfsr_q   = seed;
                phase_q  = '0;
                r.status = (taps != '0) ? ST_OK : ST_NO_TAPS;
            end
            else if (taps == '0)
            begin
                r.status = ST_NO_TAPS;
            end
            else
            begin
                s = lfsr_q & mask;
                r.out_bit = left ? s[w - 1] : s[0];
                if (galois)
                begin
                    if (left)
                        s = ((s << 1) ^ (r.out_bit ? taps : '0)) & mask;
                    else
                        s = (s >> 1) ^ (r.out_bit ? taps : '0);
                end
                else
                begin
                    nb = ^(taps & s);
                    if (left)
                        s = ((s << 1) | 64'(nb)) & mask;
                    else
                        s = (s >> 1) | (64'(nb) << (w - 1));
                end
                lfsr_q = s & mask;

                // phase wraps at the maximal period of the current width
                nxt = phase_q + 64'd1;
                if (nxt >= mask)
                    nxt = '0;
                phase_q = nxt;

                r.period_complete = (lfsr_q == seed);
                if (check_on && (lfsr_q == '0 || r.period_complete != (phase_q == '0)))
                    r.status = ST_CHECK_FAIL;
            end

            r.state_value = lfsr_q;
            r.phase_count = phase_q;
            owed_steps.push_back(r);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: %s", msg);
        endfunction

        // compare one output transfer against the oldest owed step
        function void check_transfer(lfsr_step_t got);
            lfsr_step_t want;
            string      what;

            if (owed_steps.size() == 0)
            begin
                flag($sformatf("unexpected result, state %h phase %h status %0d",
                               got.state_value, got.phase_count, got.status));
                return;
            end
            want = owed_steps.pop_front();
            what = "";
            if (got.out_bit !== want.out_bit)
                what = {what, " out_bit"};
            if (got.state_value !== want.state_value)
                what = {what, " state_value"};
            if (got.phase_count !== want.phase_count)
                what = {what, " phase_count"};
            if (got.period_complete !== want.period_complete)
                what = {what, " period_complete"};
            if (got.status !== want.status)
                what = {what, " status"};

            if (what != "")
                flag($sformatf({"after %0d good steps,%s differ\n",
                                "  expected bit %b state %h phase %h done %b status %0d\n",
                                "  actual   bit %b state %h phase %h done %b status %0d"},
                               matched, what,
                               want.out_bit, want.state_value, want.phase_count,
                               want.period_complete, want.status,
                               got.out_bit, got.state_value, got.phase_count,
                               got.period_complete, got.status));
            else
                matched++;

            if (want.period_complete)
                completions++;
            if (want.status == ST_CHECK_FAIL)
                check_flags++;
            if (want.status == ST_NO_TAPS)
                no_tap_steps++;
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [2:0]           cfg_index = '0;
    logic [63:0]          cfg_wdata = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic                 restart   = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 out_bit;
    logic [63:0]          state_value;
    logic [63:0]          phase_count;
    logic                 period_complete;
    logic [1:0]           status;

    lfsr_step_checker     steps_sb = new();
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int                   cycle_count = 0;
    int                   phases_run = 0;

    configurable_lfsr_generator_core dut (.*);

    // clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // result side stalls at random
    always @(posedge clk)
        out_stall <= rst_n ? ($urandom_range(99) < recv_idle_pct) : 1'b0;

    // result side checker
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            steps_sb.check_transfer({out_bit, state_value, phase_count,
                                     period_complete, status});

    // cycle limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout, %0d steps still owed", steps_sb.pending());
        $display("RESULT: ERROR");
        $finish;
    end

    // one input transfer, with random gaps ahead of it
    task automatic send_step(input logic restart_bit);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= restart_bit;
        do
            @(posedge clk);
        while (in_stall);
        steps_sb.note_transfer(restart_bit);
    endtask

    // stop sending and let every owed step come back
    task automatic drain();
        in_valid <= 1'b0;
        while (steps_sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input clfsr_reg_t idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        steps_sb.set_reg(idx, value);
    endtask

    task automatic apply_config(input logic [63:0] size, input logic [63:0] kind,
                                input logic [63:0] dir, input logic [63:0] taps,
                                input logic [63:0] start, input logic [63:0] chk);
        drain();
        write_reg(REG_SIZE, size);
        write_reg(REG_KIND, kind);
        write_reg(REG_DIR, dir);
        write_reg(REG_TAPS, taps);
        write_reg(REG_START, start);
        write_reg(REG_CHECK, chk);
        cfg_we <= 1'b0;
        phases_run++;
    endtask

    // random data above the bits a register keeps
    function automatic logic [63:0] junk_above(input logic [63:0] v, input int bits);
        return ({$urandom(), $urandom()} << bits) | v;
    endfunction

    // random settings, then mostly restart-and-run sequences
    task automatic random_phase(input int n_steps);
        logic [6:0]  size;
        logic [63:0] taps;
        logic [63:0] start;
        int          pause_at;
        logic        rs;

        case ($urandom_range(9))
            0:       size = 7'($urandom_range(127));
            1:       size = 7'($urandom_range(25, 64));
            2, 3:    size = 7'($urandom_range(9, 24));
            default: size = 7'($urandom_range(2, 8));
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3: taps = '0;
            4, 5, 6:    taps = {$urandom(), $urandom()};
            default:    taps = {$urandom(), $urandom()} & {$urandom(), $urandom()};
        endcase
        case ($urandom_range(9))
            0, 1:    start = '0;
            2:       start = '1;
            default: start = {$urandom(), $urandom()};
        endcase
        apply_config(junk_above(64'(size), SIZE_W),
                     junk_above(64'($urandom_range(1)), 1),
                     junk_above(64'($urandom_range(1)), 1),
                     taps, start,
                     junk_above(64'($urandom_range(9) != 0), 1));

        pause_at = $urandom_range(5, n_steps - 5);
        for (int i = 0; i < n_steps; i++)
        begin
            if (i == pause_at)
                drain();
            rs = (i == 0) ? ($urandom_range(3) != 0) : ($urandom_range(24) == 0);
            send_step(rs);
        end
    endtask

    // stimulus
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 38;
        recv_idle_pct = 54;

        // reset settings: steps from the reset seed, then restart and run
        send_step(1'b0);
        send_step(1'b0);
        send_step(1'b1);
        send_step(1'b0);
        send_step(1'b0);
        send_step(1'b0);

        // width below range acts as 2, stale state and phase past the period
        apply_config(64'd0, 64'd0, 64'd1, 64'd0, 64'd0, 64'd1);
        send_step(1'b0);
        send_step(1'b0);
        send_step(1'b0);

        // width above range acts as 64, which has no table entry
        apply_config(64'd127, 64'd1, 64'd1, 64'd0, '1, 64'd1);
        send_step(1'b0);
        send_step(1'b1);

        // wide taps and seed that mask to zero, galois shifting right
        apply_config(64'd8, 64'd1, 64'd0, 64'hffff_ffff_ffff_ff00,
                     64'hffff_ffff_ffff_ff00, 64'd1);
        send_step(1'b1);
        send_step(1'b0);
        send_step(1'b0);

        // short cycle returns to the seed early, the check flags it
        apply_config(64'd2, 64'd0, 64'd0, 64'hffff_ffff_ffff_fffd,
                     64'hffff_ffff_ffff_fffd, 64'd1);
        send_step(1'b1);
        send_step(1'b0);
        send_step(1'b0);

        // galois left with custom taps and the check off
        apply_config(64'd5, 64'd1, 64'd1, 64'h12, 64'h15, 64'd0);
        send_step(1'b1);
        send_step(1'b0);
        send_step(1'b0);
        send_step(1'b0);

        // full width, all taps, all-ones seed, fibonacci left
        apply_config(64'd64, 64'd0, 64'd1, '1, 64'd0, 64'd1);
        send_step(1'b1);
        send_step(1'b0);
        send_step(1'b0);

        // random settings under three idling mixes
        for (int mix = 0; mix < 3; mix++)
        begin
            drain();
            send_idle_pct = (mix == 0) ? 38 : ((mix == 1) ? 54 : 0);
            recv_idle_pct = (mix == 0) ? 54 : ((mix == 1) ? 38 : 0);
            repeat (6) random_phase(30);
        end

        drain();
        $display("checked %0d steps over %0d settings in %0d cycles",
                 steps_sb.matched + steps_sb.mismatches, phases_run, cycle_count);
        $display("seen %0d period completions, %0d check flags, %0d no-tap steps, %0d bad",
                 steps_sb.completions, steps_sb.check_flags, steps_sb.no_tap_steps,
                 steps_sb.mismatches);
        if (steps_sb.mismatches == 0 && steps_sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
